>>> hdl/ubl_pkg.sv
// ----------------------------------------------------------------------------
// ubl_pkg
// Shared types, field widths and codes for the uniform block layout engine.
// ----------------------------------------------------------------------------
package ubl_pkg;

   // defaults for the top level parameters
   localparam int unsigned MAX_ARRAY_LEN_DEF = 255;
   localparam int unsigned SIZE_BITS_DEF     = 16;

   // field widths
   localparam int unsigned TYPE_W = 3;
   localparam int unsigned LEN_W  = 8;
   localparam int unsigned SET_W  = 4;
   localparam int unsigned OFS_W  = 16;
   localparam int unsigned TEX_W  = 8;
   // widest size or alignment: mat4 times a full length array
   localparam int unsigned SZ_W   = LEN_W + 6;

   localparam logic [SET_W-1:0] PUSH_SET   = SET_W'(3);
   localparam int unsigned      PUSH_LIMIT = 128;
   localparam logic [TEX_W-1:0] TEX_MAX    = {TEX_W{1'b1}};

   typedef enum logic [TYPE_W-1:0] {
      BT_FLOAT      = 3'd0,
      BT_VEC2       = 3'd1,
      BT_VEC3       = 3'd2,
      BT_VEC4       = 3'd3,
      BT_MAT4       = 3'd4,
      BT_TEX2D      = 3'd5,
      BT_TEX_SHADOW = 3'd6
   } base_type_type;

   typedef struct packed {
      logic [TYPE_W-1:0] base_type;
      logic [LEN_W-1:0]  array_len;
      logic [SET_W-1:0]  set_index;
      logic              last;
   } req_payload_type;

   typedef struct packed {
      logic             is_resource;
      logic [OFS_W-1:0] uniform_offset;
      logic [OFS_W-1:0] total_size;
      logic [TEX_W-1:0] texture_total;
      logic             push_constant;
      logic             overflow;
      logic             block_end;
   } rsp_payload_type;

   // decoded footprint of one parameter
   typedef struct packed {
      logic            is_tex;
      logic [SZ_W-1:0] size;
      logic [SZ_W-1:0] align;
   } size_info_type;

endpackage

>>> hdl/ubl_if.sv
// ----------------------------------------------------------------------------
// ubl_req_if / ubl_rsp_if
// Valid/ready channels carrying parameter items and layout result items.
// ----------------------------------------------------------------------------
interface ubl_req_if;
   import ubl_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ubl_rsp_if;
   import ubl_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/ubl_size.sv
// ----------------------------------------------------------------------------
// ubl_size
// Type decoder: byte size and alignment of one parameter from its base type
// and array length.
// ----------------------------------------------------------------------------
module ubl_size #(
   parameter int unsigned MAX_ARRAY_LEN = ubl_pkg::MAX_ARRAY_LEN_DEF
) (
   input  logic [ubl_pkg::TYPE_W-1:0] base_type,
   input  logic [ubl_pkg::LEN_W-1:0]  array_len,
   output ubl_pkg::size_info_type     info
);
   import ubl_pkg::*;

   localparam int unsigned LenCap = (MAX_ARRAY_LEN > 255) ? 255 : MAX_ARRAY_LEN;

   logic [LEN_W-1:0] len_c;
   logic [SZ_W-1:0]  len_w;
   logic [SZ_W-1:0]  len_n;

   always_comb begin
      len_c = (array_len > LEN_W'(LenCap)) ? LEN_W'(LenCap) : array_len;
      len_w = SZ_W'(len_c);
      // a plain uniform counts as one element
      len_n = (len_c == '0) ? SZ_W'(1) : len_w;
   end

   always_comb begin
      info.is_tex = 1'b0;
      info.size   = '0;
      info.align  = SZ_W'(1);
      unique case (base_type) inside
         BT_FLOAT: begin
            info.size  = len_n << 2;
            info.align = SZ_W'(4);
         end
         BT_VEC2: begin
            info.size  = len_n << 3;
            info.align = SZ_W'(8);
         end
         BT_VEC3: begin
            if (len_c != '0) begin
               // 12 bytes per element, aligned to the whole array
               info.size  = (len_w << 3) + (len_w << 2);
               info.align = (len_w << 3) + (len_w << 2);
            end else begin
               info.size  = SZ_W'(16);
               info.align = SZ_W'(16);
            end
         end
         BT_VEC4: begin
            info.size  = len_n << 4;
            info.align = SZ_W'(16);
         end
         BT_MAT4: begin
            info.size  = len_n << 6;
            info.align = SZ_W'(16);
         end
         BT_TEX2D, BT_TEX_SHADOW: begin
            info.is_tex = 1'b1;
         end
         default: begin
            // unknown type: zero size, alignment one
            info.size  = '0;
            info.align = SZ_W'(1);
         end
      endcase
   end

endmodule

>>> hdl/ubl_rem.sv
// ----------------------------------------------------------------------------
// ubl_rem
// Bit-serial restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ubl_rem #(
   parameter int unsigned DIV_W = ubl_pkg::SIZE_BITS_DEF,
   parameter int unsigned VAL_W = ubl_pkg::SZ_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [VAL_W-1:0] divisor,
   output logic             done,
   output logic [VAL_W-1:0] remainder
);
   localparam int unsigned CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;
   localparam logic [CNT_W-1:0] CntLast = CNT_W'(DIV_W - 1);

   logic [DIV_W-1:0] shift_ff, shift_in;
   logic [VAL_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [VAL_W:0]   trial;
   logic [VAL_W:0]   diff;

   always_comb begin
      // partial remainder stays below the divisor, so the trial fits
      trial    = {rem_ff, shift_ff[DIV_W-1]};
      diff     = trial - {1'b0, divisor};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         rem_in   = (trial >= {1'b0, divisor}) ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
         cnt_in   = cnt_ff + CNT_W'(1);
         if (cnt_ff == CntLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> hdl/uniform_block_layout.sv
// ----------------------------------------------------------------------------
// uniform_block_layout
// std140 style layout of a block of shader parameters, one item at a time.
//
//   channel  dir  handshake     payload
//   req_chan in   valid/ready   base_type, array_len, set_index, last
//   rsp_chan out  valid/ready   resource, offset, totals, push-constant, overflow, end
//
// A uniform item is accepted, then the bit-serial remainder unit steps
// through the SIZE_BITS bits of the running size for the remainder that
// rounds it up to the alignment; it is handed over and the item commits.
// A texture item skips the remainder. Synchronous reset clears the running
// size, texture count and overflow flag. A stalled result stays in the
// output register; one more item is taken meanwhile and waits to commit.
// ----------------------------------------------------------------------------
module uniform_block_layout #(
   parameter int unsigned MAX_ARRAY_LEN = ubl_pkg::MAX_ARRAY_LEN_DEF,
   parameter int unsigned SIZE_BITS     = ubl_pkg::SIZE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ubl_req_if.sink   req_chan,
   ubl_rsp_if.source rsp_chan
);
   import ubl_pkg::*;

   localparam int unsigned SUM_W = ((SIZE_BITS > SZ_W) ? SIZE_BITS : SZ_W) + 1;
   localparam logic [SUM_W-1:0] Limit = SUM_W'({SIZE_BITS{1'b1}});

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   req_payload_type  item_ff, item_in;
   logic [SIZE_BITS-1:0] run_ff, run_in;
   logic [TEX_W-1:0] tex_ff, tex_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   size_info_type    info;
   logic             div_done;
   logic [SZ_W-1:0]  rem;
   logic             accept;
   logic             commit;
   logic [SUM_W-1:0] off_raw;
   logic [SUM_W-1:0] off_sat;
   logic [SUM_W-1:0] end_raw;
   logic [SUM_W-1:0] run_new;
   logic [TEX_W-1:0] tex_new;
   logic             ovf_new;

   ubl_size #(
      .MAX_ARRAY_LEN (MAX_ARRAY_LEN)
   ) u_size (
      .base_type (item_ff.base_type),
      .array_len (item_ff.array_len),
      .info      (info)
   );

   ubl_rem #(
      .DIV_W (SIZE_BITS),
      .VAL_W (SZ_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (run_ff),
      .divisor   (info.align),
      .done      (div_done),
      .remainder (rem)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign commit         = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // round up, saturate, then add the size; a texture gets offset zero and bumps the texture count
   always_comb begin
      off_raw = SUM_W'(run_ff);
      if (rem != '0) begin
         off_raw = SUM_W'(run_ff) + SUM_W'(info.align) - SUM_W'(rem);
      end
      off_sat = (off_raw > Limit) ? Limit : off_raw;
      end_raw = off_sat + SUM_W'(info.size);
      ovf_new = ovf_ff;
      tex_new = tex_ff;
      if (info.is_tex) begin
         off_sat = '0;
         run_new = SUM_W'(run_ff);
         if (tex_ff != TEX_MAX) begin
            tex_new = tex_ff + TEX_W'(1);
         end
      end else begin
         run_new = (end_raw > Limit) ? Limit : end_raw;
         if (off_raw > Limit || end_raw > Limit) begin
            ovf_new = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      run_in       = run_ff;
      tex_in       = tex_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_chan.payload;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (info.is_tex || div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.is_resource    = info.is_tex;
               rsp_data_in.uniform_offset = OFS_W'(off_sat);
               rsp_data_in.total_size     = OFS_W'(run_new);
               rsp_data_in.texture_total  = tex_new;
               rsp_data_in.push_constant  = item_ff.last && (item_ff.set_index == PUSH_SET)
                                            && (run_new <= SUM_W'(PUSH_LIMIT));
               rsp_data_in.overflow       = ovf_new;
               rsp_data_in.block_end      = item_ff.last;
               if (item_ff.last) begin
                  run_in = '0;
                  tex_in = '0;
                  ovf_in = 1'b0;
               end else begin
                  run_in = SIZE_BITS'(run_new);
                  tex_in = tex_new;
                  ovf_in = ovf_new;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= '0;
         tex_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         tex_ff       <= tex_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule
